[hw/rtl/aco_pkg.sv]
// Shared types, constants and codes for the affine Collatz orbit classifier.
// Depends on nothing; every other file of the block refers to it by scoped names.
package aco_pkg;

   // Field widths of the channels.
   localparam int DEFAULT_WORD_WIDTH = 64;
   localparam int COEFF_WIDTH        = 8;
   localparam int SEED_COUNT_WIDTH   = 11;
   localparam int STEP_LIMIT_WIDTH   = 16;
   localparam int CLASS_WIDTH        = 2;
   localparam int RESULT_WIDTH       = 64;
   localparam int CSR_INDEX_WIDTH    = 2;
   localparam int CSR_DATA_WIDTH     = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED_COUNT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_LIMIT = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [SEED_COUNT_WIDTH-1:0] SEED_COUNT_RESET = 11'd10;
   localparam logic [STEP_LIMIT_WIDTH-1:0] STEP_LIMIT_RESET = 16'd200;

   // The seed whose result is reported on its own.
   localparam logic [SEED_COUNT_WIDTH-1:0] FIRST_SEED = 11'd1;

   // Classification codes.
   localparam logic [CLASS_WIDTH-1:0] CLASS_ALL_ESCAPED  = 2'd0;
   localparam logic [CLASS_WIDTH-1:0] CLASS_SOME_ESCAPED = 2'd1;
   localparam logic [CLASS_WIDTH-1:0] CLASS_MIXED        = 2'd2;
   localparam logic [CLASS_WIDTH-1:0] CLASS_UNIFORM      = 2'd3;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_STEP,
      ST_PROD,
      ST_LOAD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic seed_init;
      logic step;
      logic prod;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic orbit_done;
      logic last_seed;
      logic count_zero;
   } status_type;

endpackage

[hw/rtl/aco_req_if.sv]
// Input channel of the orbit classifier: one coefficient pair per word.
// Depends on aco_pkg for the field widths.
interface aco_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [aco_pkg::COEFF_WIDTH-1:0] mult_coeff;
   logic signed [aco_pkg::COEFF_WIDTH-1:0] add_coeff;

   modport source (output valid, output mult_coeff, output add_coeff, input ready);
   modport sink (input valid, input mult_coeff, input add_coeff, output ready);
endinterface

[hw/rtl/aco_rsp_if.sv]
// Result channel of the orbit classifier: one classification word per pair.
// Depends on aco_pkg for the field widths.
interface aco_rsp_if;
   logic                                         valid;
   logic                                         ready;
   logic        [aco_pkg::CLASS_WIDTH-1:0]       map_class;
   logic        [aco_pkg::SEED_COUNT_WIDTH-1:0]  escaped_count;
   logic signed [aco_pkg::RESULT_WIDTH-1:0]      minima_sum;
   logic signed [aco_pkg::RESULT_WIDTH-1:0]      first_minimum;
   logic                                         first_escaped;

   modport source (output valid, output map_class, output escaped_count,
                   output minima_sum, output first_minimum, output first_escaped,
                   input ready);
   modport sink (input valid, input map_class, input escaped_count,
                 input minima_sum, input first_minimum, input first_escaped,
                 output ready);
endinterface

[hw/rtl/aco_csr_if.sv]
// Configuration write channel of the orbit classifier.
// Depends on aco_pkg for the index and data widths.
interface aco_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [aco_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [aco_pkg::CSR_DATA_WIDTH-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/aco_ctrl.sv]
// Controller of the orbit classifier: sequences seeds, orbit steps and the result.
// Depends on aco_pkg for the state, command and status types.
module aco_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   input  aco_pkg::status_type status,
   output aco_pkg::cmd_type    cmd
);

   aco_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // The output register can take a new word when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aco_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.count_zero ? aco_pkg::ST_PROD : aco_pkg::ST_SEED;
            end
         end
         aco_pkg::ST_SEED: begin
            state_in = aco_pkg::ST_STEP;
         end
         aco_pkg::ST_STEP: begin
            if (status.orbit_done) begin
               state_in = status.last_seed ? aco_pkg::ST_PROD : aco_pkg::ST_SEED;
            end
         end
         aco_pkg::ST_PROD: begin
            state_in = aco_pkg::ST_LOAD;
         end
         aco_pkg::ST_LOAD: begin
            if (out_free) begin
               state_in = aco_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aco_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         aco_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         aco_pkg::ST_SEED: begin
            cmd.seed_init = 1'b1;
         end
         aco_pkg::ST_STEP: begin
            cmd.step = 1'b1;
         end
         aco_pkg::ST_PROD: begin
            cmd.prod = 1'b1;
         end
         aco_pkg::ST_LOAD: begin
            cmd.load_out = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Result valid flag: set on load, cleared when the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aco_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/aco_dp.sv]
// Datapath of the orbit classifier: configuration, orbit step unit,
// accumulators and the output register. Depends on aco_pkg.
module aco_dp #(
   parameter int WORD_WIDTH = aco_pkg::DEFAULT_WORD_WIDTH
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_write,
   input  logic [aco_pkg::CSR_INDEX_WIDTH-1:0]           csr_index,
   input  logic [aco_pkg::CSR_DATA_WIDTH-1:0]            csr_data,
   input  logic signed [aco_pkg::COEFF_WIDTH-1:0]        mult_coeff,
   input  logic signed [aco_pkg::COEFF_WIDTH-1:0]        add_coeff,
   input  aco_pkg::cmd_type                              cmd,
   output aco_pkg::status_type                           status,
   output logic [aco_pkg::CLASS_WIDTH-1:0]               map_class,
   output logic [aco_pkg::SEED_COUNT_WIDTH-1:0]          escaped_count,
   output logic signed [aco_pkg::RESULT_WIDTH-1:0]       minima_sum,
   output logic signed [aco_pkg::RESULT_WIDTH-1:0]       first_minimum,
   output logic                                          first_escaped
);

   localparam int CW = aco_pkg::COEFF_WIDTH;
   localparam int SW = aco_pkg::SEED_COUNT_WIDTH;
   localparam int LW = aco_pkg::STEP_LIMIT_WIDTH;

   // Configuration registers.
   logic [SW-1:0] seed_count_ff;
   logic [LW-1:0] step_limit_ff;

   // Per-pair and per-orbit working registers.
   logic signed [CW-1:0]          a_ff, b_ff;
   logic [SW-1:0]                 seed_ff;
   logic signed [WORD_WIDTH-1:0]  n_ff, mn_ff;
   logic [LW-1:0]                 upd_ff;
   logic                          ret_pend_ff;
   logic [SW-1:0]                 esc_cnt_ff;
   logic signed [WORD_WIDTH-1:0]  sum_ff, first_min_ff, prod_ff;
   logic                          first_esc_ff;

   // Output register.
   logic [aco_pkg::CLASS_WIDTH-1:0] out_class_ff;
   logic [SW-1:0]                   out_esc_ff;
   logic signed [WORD_WIDTH-1:0]    out_sum_ff, out_fmin_ff;
   logic                            out_fesc_ff;

   // Orbit step signals.
   logic signed [WORD_WIDTH+CW-1:0] mul_full;
   logic signed [WORD_WIDTH-1:0]    b_ext, n_new, mn_new, orbit_min, seed_word;
   logic [LW:0]                     upd_next;
   logic                            ret_hit, n_zero, escape, orbit_done, orbit_esc;
   logic [WORD_WIDTH+SW-1:0]        cnt_prod_full;
   logic [aco_pkg::CLASS_WIDTH-1:0] class_in;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_count_ff <= aco_pkg::SEED_COUNT_RESET;
         step_limit_ff <= aco_pkg::STEP_LIMIT_RESET;
      end else if (csr_write) begin
         if (csr_index == aco_pkg::CSR_SEED_COUNT) begin
            seed_count_ff <= csr_data[SW-1:0];
         end
         if (csr_index == aco_pkg::CSR_STEP_LIMIT) begin
            step_limit_ff <= csr_data[LW-1:0];
         end
      end
   end

   // One map update: halve even values, a*n+b for odd ones, wrapping on the word.
   assign mul_full = a_ff * n_ff;
   assign b_ext    = WORD_WIDTH'(b_ff);
   assign n_new    = n_ff[0] ? ($signed(mul_full[WORD_WIDTH-1:0]) + b_ext) : (n_ff >>> 1);
   assign mn_new   = (n_ff < mn_ff) ? n_ff : mn_ff;

   // The return test of the previous update is made on the registered values.
   assign ret_hit    = ret_pend_ff && (n_ff == mn_ff);
   assign n_zero     = (n_ff == '0);
   assign upd_next   = {1'b0, upd_ff} + (LW+1)'(1);
   assign escape     = upd_next >= {1'b0, step_limit_ff};
   assign orbit_done = ret_hit || n_zero || escape;
   assign orbit_esc  = !ret_hit && !n_zero && escape;
   assign orbit_min  = ret_hit ? mn_ff : '0;
   assign seed_word  = WORD_WIDTH'(seed_ff);

   assign status.orbit_done = orbit_done;
   assign status.last_seed  = (seed_ff == seed_count_ff);
   assign status.count_zero = (seed_count_ff == '0);

   // Orbit and accumulator registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         a_ff         <= mult_coeff;
         b_ff         <= add_coeff;
         seed_ff      <= aco_pkg::FIRST_SEED;
         esc_cnt_ff   <= '0;
         sum_ff       <= '0;
         first_min_ff <= '0;
         first_esc_ff <= 1'b0;
      end
      if (cmd.seed_init) begin
         n_ff        <= seed_word;
         mn_ff       <= seed_word;
         upd_ff      <= '0;
         ret_pend_ff <= 1'b0;
      end
      if (cmd.step) begin
         if (orbit_done) begin
            if (orbit_esc) begin
               esc_cnt_ff <= esc_cnt_ff + SW'(1);
            end else begin
               sum_ff <= sum_ff + orbit_min;
            end
            if (seed_ff == aco_pkg::FIRST_SEED) begin
               first_min_ff <= orbit_min;
               first_esc_ff <= orbit_esc;
            end
            seed_ff <= seed_ff + SW'(1);
         end else begin
            n_ff        <= n_new;
            mn_ff       <= mn_new;
            upd_ff      <= upd_next[LW-1:0];
            ret_pend_ff <= 1'b1;
         end
      end
      if (cmd.prod) begin
         prod_ff <= cnt_prod_full[WORD_WIDTH-1:0];
      end
   end

   // Seed count times the first minimum, wrapped to the word.
   assign cnt_prod_full = seed_count_ff * first_min_ff;

   // Classification of the pair.
   always_comb begin
      if (seed_count_ff == '0) begin
         class_in = aco_pkg::CLASS_MIXED;
      end else if (esc_cnt_ff != '0) begin
         class_in = (esc_cnt_ff == seed_count_ff) ? aco_pkg::CLASS_ALL_ESCAPED
                                                  : aco_pkg::CLASS_SOME_ESCAPED;
      end else begin
         class_in = (sum_ff == prod_ff) ? aco_pkg::CLASS_UNIFORM : aco_pkg::CLASS_MIXED;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_class_ff <= class_in;
         out_esc_ff   <= esc_cnt_ff;
         out_sum_ff   <= sum_ff;
         out_fmin_ff  <= first_min_ff;
         out_fesc_ff  <= first_esc_ff;
      end
   end

   assign map_class     = out_class_ff;
   assign escaped_count = out_esc_ff;
   assign minima_sum    = aco_pkg::RESULT_WIDTH'(out_sum_ff);
   assign first_minimum = aco_pkg::RESULT_WIDTH'(out_fmin_ff);
   assign first_escaped = out_fesc_ff;

endmodule

[hw/rtl/affine_collatz_orbit_classifier.sv]
// Top level of the affine Collatz orbit classifier: controller plus datapath.
// Depends on aco_pkg, the three channel interfaces, aco_ctrl and aco_dp.
//
//   Channel  Direction  Word contents
//   req_ch   in         mult_coeff, add_coeff
//   rsp_ch   out        map_class, escaped_count, minima_sum, first_minimum,
//                       first_escaped
//   csr_ch   in         index, data (seed_count at 0, step_limit at 1)
//
// Each seed is set up in ST_SEED and then stepped in ST_STEP until its orbit
// returns, reaches zero or escapes; a pair is accepted in ST_IDLE, its product
// is registered in ST_PROD and its class and result are loaded in ST_LOAD.
// The shared orbit step unit makes one update per cycle. Pairs are handled one
// at a time. Reset sets seed_count to 10 and step_limit to 200 and empties the
// result. A result waiting on rsp_ch holds the next result in ST_LOAD; csr_ch is always ready.
module affine_collatz_orbit_classifier #(
   parameter int WORD_WIDTH = aco_pkg::DEFAULT_WORD_WIDTH
) (
   input logic      clock,
   input logic      reset,
   aco_req_if.sink  req_ch,
   aco_rsp_if.source rsp_ch,
   aco_csr_if.sink  csr_ch
);

   aco_pkg::cmd_type    cmd;
   aco_pkg::status_type status;

   // Configuration writes are always accepted.
   assign csr_ch.ready = 1'b1;

   aco_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   aco_dp #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .mult_coeff    (req_ch.mult_coeff),
      .add_coeff     (req_ch.add_coeff),
      .cmd           (cmd),
      .status        (status),
      .map_class     (rsp_ch.map_class),
      .escaped_count (rsp_ch.escaped_count),
      .minima_sum    (rsp_ch.minima_sum),
      .first_minimum (rsp_ch.first_minimum),
      .first_escaped (rsp_ch.first_escaped)
   );

endmodule

[bench/tb_affine_collatz_orbit_classifier.sv]
// Self-checking testbench for the affine Collatz orbit classifier: drives coefficient
// pairs and register writes and checks every result word against a built-in predictor.
// Depends on aco_pkg, the aco_req_if, aco_rsp_if and aco_csr_if interfaces, and the RTL.
module tb_affine_collatz_orbit_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_CHUNKS = 12;
   localparam int CHUNK_PAIRS   = 25;
   // Upper bound on seeds times updates for one random pair, to keep the run short.
   localparam int COST_CAP      = 1500;
   // Register indexes that decode to nothing.
   localparam logic [aco_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [aco_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      logic [aco_pkg::CLASS_WIDTH-1:0]      map_class;
      logic [aco_pkg::SEED_COUNT_WIDTH-1:0] escaped_count;
      longint                               minima_sum;
      longint                               first_minimum;
      logic                                 first_escaped;
   } pair_verdict_type;

   logic clock;
   logic reset;

   aco_req_if req_ch ();
   aco_rsp_if rsp_ch ();
   aco_csr_if csr_ch ();

   // Mirror of the configuration registers.
   logic [aco_pkg::SEED_COUNT_WIDTH-1:0] seed_count_cfg;
   logic [aco_pkg::STEP_LIMIT_WIDTH-1:0] step_limit_cfg;

   pair_verdict_type verdicts_due[$];
   int failures;
   int pairs_sent;
   int settings_used;
   int cycle_count;
   int class_seen [4];
   int req_idle_pct;
   int rsp_idle_pct;

   affine_collatz_orbit_classifier i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Follows one orbit from a seed; returns whether it escaped and its minimum.
   function automatic void walk_orbit(input longint seed, input longint mult,
                                      input longint add, input int unsigned limit,
                                      output logic escaped, output longint lowest);
      longint n;
      longint low;
      int unsigned steps;
      n = seed;
      low = seed;
      steps = 0;
      escaped = 1'b0;
      forever begin
         if (n < low) low = n;
         if (n[0] == 1'b0) begin
            if (n == 0) begin
               low = 0;
               break;
            end
            n = n >>> 1;
         end else begin
            n = mult * n + add;
         end
         steps++;
         // A limit of zero trips on the first update, the same as a limit of one.
         if (steps >= limit) begin
            escaped = 1'b1;
            low = 0;
            break;
         end
         if (n == low) break;
      end
      lowest = low;
   endfunction

   // Runs every seed under the current registers and classifies the pair.
   function automatic pair_verdict_type classify_pair(
         input logic signed [aco_pkg::COEFF_WIDTH-1:0] mult,
         input logic signed [aco_pkg::COEFF_WIDTH-1:0] add);
      pair_verdict_type v;
      longint sum;
      longint low;
      longint first_low;
      logic escaped;
      logic first_esc;
      int esc;
      int seeds;
      sum = 0;
      first_low = 0;
      first_esc = 1'b0;
      esc = 0;
      seeds = int'(seed_count_cfg);
      for (int s = 1; s <= seeds; s++) begin
         walk_orbit(longint'(s), longint'(mult), longint'(add), int'(step_limit_cfg),
                    escaped, low);
         if (escaped) esc++;
         else sum += low;
         if (s == 1) begin
            first_esc = escaped;
            first_low = low;
         end
      end
      if (seeds == 0) v.map_class = aco_pkg::CLASS_MIXED;
      else if (esc > 0) v.map_class = (esc == seeds) ? aco_pkg::CLASS_ALL_ESCAPED
                                                     : aco_pkg::CLASS_SOME_ESCAPED;
      else if (sum == longint'(seeds) * first_low) v.map_class = aco_pkg::CLASS_UNIFORM;
      else v.map_class = aco_pkg::CLASS_MIXED;
      v.escaped_count = esc[aco_pkg::SEED_COUNT_WIDTH-1:0];
      v.minima_sum = sum;
      v.first_minimum = first_low;
      v.first_escaped = first_esc;
      return v;
   endfunction

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Result receiver: ready follows the current stall rate, changed on falling edges.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Compare each accepted result word with the oldest expected one.
   always @(posedge clock) begin
      pair_verdict_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (verdicts_due.size() == 0) begin
            $error("result word with no pair outstanding: map_class %0d", rsp_ch.map_class);
            failures++;
         end else begin
            want = verdicts_due.pop_front();
            class_seen[rsp_ch.map_class]++;
            if (rsp_ch.map_class !== want.map_class) begin
               $error("map_class: expected %0d, got %0d", want.map_class, rsp_ch.map_class);
               failures++;
            end
            if (rsp_ch.escaped_count !== want.escaped_count) begin
               $error("escaped_count: expected %0d, got %0d",
                      want.escaped_count, rsp_ch.escaped_count);
               failures++;
            end
            if (rsp_ch.minima_sum !== want.minima_sum) begin
               $error("minima_sum: expected %0d, got %0d", want.minima_sum, rsp_ch.minima_sum);
               failures++;
            end
            if (rsp_ch.first_minimum !== want.first_minimum) begin
               $error("first_minimum: expected %0d, got %0d",
                      want.first_minimum, rsp_ch.first_minimum);
               failures++;
            end
            if (rsp_ch.first_escaped !== want.first_escaped) begin
               $error("first_escaped: expected %0d, got %0d",
                      want.first_escaped, rsp_ch.first_escaped);
               failures++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   task automatic set_idling(input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
   endtask

   // Sends one pair word; the expected result is queued when the word is taken.
   task automatic send_pair(input logic signed [aco_pkg::COEFF_WIDTH-1:0] mult,
                            input logic signed [aco_pkg::COEFF_WIDTH-1:0] add);
      pair_verdict_type verdict;
      verdict = classify_pair(mult, add);
      @(negedge clock);
      if ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         req_ch.mult_coeff <= aco_pkg::COEFF_WIDTH'($urandom);
         req_ch.add_coeff <= aco_pkg::COEFF_WIDTH'($urandom);
         do @(negedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.mult_coeff <= mult;
      req_ch.add_coeff <= add;
      do @(posedge clock); while (!req_ch.ready);
      verdicts_due.push_back(verdict);
      pairs_sent++;
   endtask

   // Drops the request valid so no stale word is taken while waiting.
   task automatic park_req();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // Writes one register once every outstanding result has come back.
   task automatic csr_write(input logic [aco_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [aco_pkg::CSR_DATA_WIDTH-1:0] data);
      park_req();
      while (verdicts_due.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      if (index == aco_pkg::CSR_SEED_COUNT) begin
         seed_count_cfg = data[aco_pkg::SEED_COUNT_WIDTH-1:0];
      end else if (index == aco_pkg::CSR_STEP_LIMIT) begin
         step_limit_cfg = data;
      end
      settings_used++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Extreme and well-known coefficient pairs under the reset settings.
   task automatic test_reset_settings();
      send_pair(3, 1);
      send_pair(3, -1);
      send_pair(1, 1);
      send_pair(0, 0);
      send_pair(127, 127);
      send_pair(-128, -128);
      send_pair(127, -128);
      send_pair(-128, 127);
      send_pair(1, -1);
      send_pair(-1, 1);
      send_pair(-1, -1);
      send_pair(0, 1);
      send_pair(5, 1);
      send_pair(-3, 1);
   endtask

   // No seeds, one seed, the full 2047 seeds, 1024 seeds with a zero limit, high data bits.
   task automatic test_seed_count_edges();
      csr_write(aco_pkg::CSR_SEED_COUNT, 16'd0);
      send_pair(3, 1);
      send_pair(127, 127);
      csr_write(aco_pkg::CSR_SEED_COUNT, 16'd1);
      send_pair(3, 1);
      send_pair(-1, 0);
      csr_write(aco_pkg::CSR_STEP_LIMIT, 16'd1);
      csr_write(aco_pkg::CSR_SEED_COUNT, 16'd2047);
      send_pair(3, 1);
      csr_write(aco_pkg::CSR_STEP_LIMIT, 16'd0);
      csr_write(aco_pkg::CSR_SEED_COUNT, 16'd1024);
      send_pair(1, 1);
      csr_write(aco_pkg::CSR_SEED_COUNT, 16'hF805);
      send_pair(3, 1);
   endtask

   // The longest step limit on a single seed, then a very short one.
   task automatic test_step_limit_edges();
      csr_write(aco_pkg::CSR_SEED_COUNT, 16'd1);
      csr_write(aco_pkg::CSR_STEP_LIMIT, 16'hFFFF);
      send_pair(127, 127);
      send_pair(5, 1);
      csr_write(aco_pkg::CSR_STEP_LIMIT, 16'd2);
      csr_write(aco_pkg::CSR_SEED_COUNT, 16'd10);
      send_pair(3, 1);
   endtask

   // Writes to undecoded indexes must leave both registers alone.
   task automatic test_spare_indexes();
      csr_write(CSR_SPARE_LO, 16'hFFFF);
      csr_write(CSR_SPARE_HI, 16'h0000);
      send_pair(3, 1);
   endtask

   // Random pairs in chunks, each chunk under fresh random register settings.
   task automatic test_random_pairs();
      int steps;
      int seeds;
      int cap;
      int pick;
      logic signed [aco_pkg::COEFF_WIDTH-1:0] mult;
      logic signed [aco_pkg::COEFF_WIDTH-1:0] add;
      for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
         if (chunk < RANDOM_CHUNKS / 3) set_idling(27, 65);
         else if (chunk < 2 * RANDOM_CHUNKS / 3) set_idling(65, 27);
         else set_idling(0, 0);
         pick = $urandom_range(99);
         if (pick < 10) steps = $urandom_range(3, 0);
         else if (pick < 80) steps = $urandom_range(80, 4);
         else steps = $urandom_range(400, 81);
         cap = COST_CAP / (steps + 2);
         pick = $urandom_range(9);
         if (pick == 0) seeds = 0;
         else if (pick <= 6) seeds = $urandom_range((cap < 12) ? cap : 12, 1);
         else seeds = $urandom_range(cap, 1);
         csr_write(aco_pkg::CSR_STEP_LIMIT, aco_pkg::CSR_DATA_WIDTH'(steps));
         csr_write(aco_pkg::CSR_SEED_COUNT, aco_pkg::CSR_DATA_WIDTH'(seeds));
         for (int k = 0; k < CHUNK_PAIRS; k++) begin
            // Small coefficients give orbits that settle; the full range mostly escapes.
            if ($urandom_range(99) < 60) begin
               mult = aco_pkg::COEFF_WIDTH'(int'($urandom_range(10)) - 5);
               add = aco_pkg::COEFF_WIDTH'(int'($urandom_range(10)) - 5);
            end else begin
               mult = aco_pkg::COEFF_WIDTH'($urandom);
               add = aco_pkg::COEFF_WIDTH'($urandom);
            end
            send_pair(mult, add);
         end
      end
   endtask

   // Test sequence.
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mult_coeff = '0;
      req_ch.add_coeff = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      seed_count_cfg = aco_pkg::SEED_COUNT_RESET;
      step_limit_cfg = aco_pkg::STEP_LIMIT_RESET;
      failures = 0;
      pairs_sent = 0;
      settings_used = 0;
      class_seen = '{default: 0};
      set_idling(27, 65);
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_settings();
      test_seed_count_edges();
      test_step_limit_edges();
      test_spare_indexes();
      test_random_pairs();

      // Let every result drain, then watch for stray words.
      park_req();
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdicts_due.size() != 0) begin
         $error("%0d expected result words never arrived", verdicts_due.size());
         failures++;
      end

      $display("Checked %0d coefficient pairs across %0d register writes in %0d cycles.",
               pairs_sent, settings_used, cycle_count);
      $display("Classes seen: all escaped %0d, some escaped %0d, mixed %0d, uniform %0d.",
               class_seen[aco_pkg::CLASS_ALL_ESCAPED], class_seen[aco_pkg::CLASS_SOME_ESCAPED],
               class_seen[aco_pkg::CLASS_MIXED], class_seen[aco_pkg::CLASS_UNIFORM]);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
